// ===== hw/rtl/plle_pkg.sv =====
`default_nettype none
package plle_pkg;

	typedef enum logic [3:0] {
		CMD_BEGIN        = 4'd0,
		CMD_GET_NEXT     = 4'd1,
		CMD_GET_VALUE    = 4'd2,
		CMD_SET_VALUE    = 4'd3,
		CMD_INSERT_AFTER = 4'd4,
		CMD_INSERT_BEGIN = 4'd5,
		CMD_DELETE_NEXT  = 4'd6,
		CMD_DELETE_BEGIN = 4'd7,
		CMD_SWAP_HALVES  = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	localparam int NodeW  = 10;
	localparam int ValueW = 32;
	localparam int CmdW   = 4;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_OP,
		S_WLK_RD,
		S_WLK_CAP,
		S_WR_RD,
		S_WR_SRC,
		S_WR_CAP,
		S_OUT
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pooled_linked_list_engine_core.sv =====
`default_nettype none
// Channel | Dir | Signals                        | Beat contents
// s_axis  | in  | s_axis_tvalid/tready/tdata     | cmd[3:0], node_index[13:4], value_in[45:14]
// m_axis  | out | m_axis_tvalid/tready/tdata     | node_out[9:0], value_out[41:10],
//         |     |                                | list_size[51:42], status[53:52]
// A command that edits or reads the list passes through two link-memory reads, the operate
// state, the result state, where it waits until the result is taken, and the idle state. A
// command ignored for its code or node index, and a short swap_halves, goes from the first
// read straight to the result. swap_halves first walks the list and buffers the values, then
// writes them back; the walk reads one link at a time, and a swap-buffer read comes ahead of
// each value write. After reset a sweep writes the free chain into the link memory while no
// beat is accepted. One command is in work at a time; a result waits in the output register
// and the next command is taken once the result has gone.
module pooled_linked_list_engine_core
	import plle_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // cmd, node_index, value_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [55:0] m_axis_tdata   // node_out, value_out, list_size, status
);

	localparam int AW = $clog2(CAPACITY);

	state_t state_q, state_d;

	logic [CmdW-1:0]   cmd_q;
	logic [NodeW-1:0]  idx_q;
	logic [ValueW-1:0] val_q;
	logic [AW-1:0]     prev_q;   // node whose link is edited
	logic [AW-1:0]     a_q;      // link of prev
	logic [AW-1:0]     b_q;      // value for the second link write
	logic [AW-1:0]     free_q;
	logic [NodeW-1:0]  count_q;
	logic [AW-1:0]     p_q;
	logic [AW-1:0]     head_q;   // first element, where the write-back starts
	logic [AW:0]       n_q;
	logic [AW:0]       k_q;
	logic [NodeW-1:0]  node_o_q;
	logic [ValueW-1:0] val_o_q;
	logic [1:0]        st_q;

	logic          lk_we;
	logic [AW-1:0] lk_wa, lk_wd, lk_ra, lk_rd;
	logic          init_busy;
	logic          dv_we, sb_we;
	logic [AW-1:0] dv_wa, dv_ra, sb_wa, sb_ra;
	logic [ValueW-1:0] dv_wd, dv_rd, sb_wd, sb_rd;

	logic [CmdW-1:0]  in_cmd;
	logic [NodeW-1:0] in_idx;
	logic             in_range;
	logic             uses_node;
	logic             acc;
	logic             is_ins, is_del;
	logic             walk_end;
	logic [AW:0]      mid, lead, src;

	assign in_cmd  = s_axis_tdata[3:0];
	assign in_idx  = s_axis_tdata[13:4];
	assign acc     = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && !init_busy;
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = {2'b0, st_q, count_q, val_o_q, node_o_q};

	assign uses_node = (cmd_q == CMD_GET_NEXT) || (cmd_q == CMD_GET_VALUE)
		|| (cmd_q == CMD_SET_VALUE) || (cmd_q == CMD_INSERT_AFTER)
		|| (cmd_q == CMD_DELETE_NEXT);
	assign in_range = ({{(17-NodeW){1'b0}}, idx_q} < 17'(CAPACITY));
	assign is_ins = (cmd_q == CMD_INSERT_AFTER) || (cmd_q == CMD_INSERT_BEGIN);
	assign is_del = (cmd_q == CMD_DELETE_NEXT) || (cmd_q == CMD_DELETE_BEGIN);

	// The walk stops at the end of the list or once element_count values are buffered.
	assign walk_end = (lk_rd == '0) || ((n_q + 1'b1) >= (AW+1)'(count_q));

	// Source slot of swap_halves for output position k.
	assign mid  = n_q >> 1;
	assign lead = n_q - mid;
	always_comb begin
		if (n_q[0]) begin
			if (k_q + 1'b1 < lead)       src = mid + 1'b1 + k_q;
			else if (k_q + 1'b1 == lead) src = mid;
			else                         src = k_q - lead;
		end else begin
			src = (k_q < lead) ? mid + k_q : k_q - lead;
		end
	end

	plle_link_mem #(.Depth(CAPACITY), .AddrW(AW)) u_link (
		.clk, .arst_n, .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
		.raddr(lk_ra), .rdata(lk_rd), .init_busy
	);
	plle_data_mem #(.Depth(CAPACITY), .AddrW(AW)) u_value (
		.clk, .we(dv_we), .waddr(dv_wa), .wdata(dv_wd), .raddr(dv_ra), .rdata(dv_rd)
	);
	plle_data_mem #(.Depth(CAPACITY), .AddrW(AW)) u_swapbuf (
		.clk, .we(sb_we), .waddr(sb_wa), .wdata(sb_wd), .raddr(sb_ra), .rdata(sb_rd)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (acc) state_d = S_RD1;
			S_RD1: begin
				if (cmd_q > CMD_SWAP_HALVES || (uses_node && (!in_range || idx_q == '0)))
					state_d = S_OUT;
				else if (cmd_q == CMD_SWAP_HALVES)
					state_d = (count_q < NodeW'(2)) ? S_OUT : S_WLK_RD;
				else
					state_d = S_RD2;
			end
			S_RD2:     state_d = S_OP;
			S_OP:      state_d = S_OUT;
			S_WLK_RD:  state_d = S_WLK_CAP;
			S_WLK_CAP: begin
				if (walk_end) state_d = S_WR_RD;
				else state_d = S_WLK_RD;
			end
			S_WR_RD:   state_d = (k_q >= n_q || p_q == '0) ? S_OUT : S_WR_SRC;
			S_WR_SRC:  state_d = S_WR_CAP;
			S_WR_CAP:  state_d = S_WR_RD;
			S_OUT:     if (m_axis_tready) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = '0;
		dv_we = 1'b0; dv_wa = '0; dv_wd = val_q; dv_ra = p_q;
		sb_we = 1'b0; sb_wa = n_q[AW-1:0]; sb_wd = dv_rd; sb_ra = src[AW-1:0];
		case (state_q)
			S_RD1: lk_ra = prev_q;
			S_RD2: lk_ra = is_ins ? free_q : lk_rd;
			S_OP: begin
				if (is_ins && free_q != '0 && count_q < NodeW'(CAPACITY-1)) begin
					// Writing link of the new node; link of prev is fixed in S_OUT entry below.
					lk_we = 1'b1; lk_wa = free_q; lk_wd = a_q;
					dv_we = 1'b1; dv_wa = free_q;
				end else if (is_del && a_q != '0 && count_q != '0) begin
					lk_we = 1'b1; lk_wa = prev_q; lk_wd = lk_rd;
				end else if (cmd_q == CMD_SET_VALUE) begin
					dv_we = 1'b1; dv_wa = prev_q;
				end
			end
			S_OUT: begin
				// Second link write of a command, done while the result waits.
				if (st_q == ST_DONE && is_ins) begin
					lk_we = 1'b1; lk_wa = prev_q; lk_wd = b_q;
				end else if (st_q == ST_DONE && is_del) begin
					lk_we = 1'b1; lk_wa = a_q; lk_wd = b_q;
				end
			end
			S_WLK_RD:  lk_ra = p_q;
			S_WLK_CAP: sb_we = 1'b1;
			S_WR_RD:   lk_ra = p_q;
			S_WR_SRC:  lk_ra = p_q;
			S_WR_CAP: begin
				dv_we = 1'b1; dv_wa = p_q; dv_wd = sb_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_q  <= AW'(1);
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OP) begin
				if (is_ins && st_q == ST_DONE && free_q != '0
						&& count_q < NodeW'(CAPACITY-1)) begin
					free_q  <= lk_rd;
					count_q <= count_q + 1'b1;
				end else if (is_del && a_q != '0 && count_q != '0) begin
					free_q  <= a_q;
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (acc) begin
				cmd_q    <= in_cmd;
				idx_q    <= in_idx;
				val_q    <= s_axis_tdata[45:14];
				prev_q   <= (in_cmd == CMD_INSERT_BEGIN || in_cmd == CMD_DELETE_BEGIN
					|| in_cmd == CMD_BEGIN || in_cmd == CMD_SWAP_HALVES) ? '0 : in_idx[AW-1:0];
				node_o_q <= '0;
				val_o_q  <= '0;
				st_q     <= ST_DONE;
				n_q      <= '0;
				k_q      <= '0;
			end
			S_RD1: begin
				if (cmd_q > CMD_SWAP_HALVES || (uses_node && !in_range))
					st_q <= ST_IGNORED;
				else if (uses_node && idx_q == '0) begin
					st_q <= ST_IGNORED;
					if (cmd_q == CMD_GET_VALUE) val_o_q <= '1;
				end else if (cmd_q == CMD_SWAP_HALVES && count_q < NodeW'(2))
					st_q <= ST_IGNORED;
				// A walk starts with a read of the sentinel link.
				p_q <= prev_q;
			end
			S_RD2: begin
				a_q <= lk_rd;
				p_q <= prev_q;
				if (cmd_q == CMD_BEGIN || cmd_q == CMD_GET_NEXT) node_o_q <= NodeW'(lk_rd);
				if (is_ins && (free_q == '0 || count_q >= NodeW'(CAPACITY-1))) st_q <= ST_FULL;
				if (is_del && (lk_rd == '0 || count_q == '0)) st_q <= ST_IGNORED;
			end
			S_OP: begin
				// An insert links prev to the new node; a delete pushes the node on the free stack.
				b_q <= free_q;
				if (cmd_q == CMD_GET_VALUE) val_o_q <= dv_rd;
			end
			S_WLK_RD: ;
			S_WLK_CAP: begin
				if (p_q == '0) begin
					head_q <= lk_rd;
				end else begin
					n_q <= n_q + 1'b1;
				end
				// At the end of the walk the write-back restarts from the first element.
				if (walk_end && p_q != '0) begin
					p_q <= head_q;
				end else begin
					p_q <= lk_rd;
				end
			end
			S_WR_RD: ;
			S_WR_SRC: ;
			S_WR_CAP: begin
				k_q <= k_q + 1'b1;
				p_q <= lk_rd;
			end
			default: ;
		endcase
	end

	property p_ready_idle;
		@(posedge clk) disable iff (!arst_n) s_axis_tready |-> !m_axis_tvalid;
	endproperty
	a_ready_idle: assert property (p_ready_idle) else $error("ready while result pending");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= NodeW'(CAPACITY-1);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("element count overflow");

	property p_full_no_grow;
		@(posedge clk) disable iff (!arst_n)
			(m_axis_tvalid && st_q == ST_FULL) |-> $stable(count_q);
	endproperty
	a_full_no_grow: assert property (p_full_no_grow) else $error("count moved on full");

endmodule
`default_nettype wire

// ===== hw/rtl/plle_link_mem.sv =====
`default_nettype none
module plle_link_mem
	import plle_pkg::*;
#(
	parameter int Depth = 1024,
	parameter int AddrW = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [AddrW-1:0] wdata,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [AddrW-1:0] rdata,
	output logic                  init_busy
);

	// The reset chain is written by a sweep after reset, one entry a cycle.
	logic [AddrW-1:0] mem [Depth];
	logic [AddrW:0]   init_ptr_q;
	logic [AddrW-1:0] init_addr;
	logic [AddrW-1:0] init_val;

	assign init_busy = (init_ptr_q != (AddrW+1)'(Depth));
	assign init_addr = init_ptr_q[AddrW-1:0];
	assign init_val  = (init_ptr_q == '0 || init_ptr_q == (AddrW+1)'(Depth-1)) ? '0
		: AddrW'(init_ptr_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_ptr_q <= '0;
		end else if (init_busy) begin
			init_ptr_q <= init_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (init_busy) begin
			mem[init_addr] <= init_val;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/plle_data_mem.sv =====
`default_nettype none
module plle_data_mem
	import plle_pkg::*;
#(
	parameter int Depth = 1024,
	parameter int AddrW = 10
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AddrW-1:0]  waddr,
	input  wire logic [ValueW-1:0] wdata,
	input  wire logic [AddrW-1:0]  raddr,
	output logic      [ValueW-1:0] rdata
);

	logic [ValueW-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
